// ===== design/ftvp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftvp_pkg
// Shared types, codes and helpers for the FIX tag=value parser.
// ----------------------------------------------------------------------------
package ftvp_pkg;

  // Byte of the message with its end-of-message flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result per input byte
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] field_tag;
    logic [7:0]  value_byte;
    logic [2:0]  message_type;
  } out_item_t;

  // Result kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_FEND   = 3'd2;
  localparam logic [2:0] KIND_ACCEPT = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  // Message type codes
  localparam logic [2:0] MT_NEW_ORDER = 3'd0;
  localparam logic [2:0] MT_CANCEL    = 3'd1;
  localparam logic [2:0] MT_EXEC_RPT  = 3'd2;
  localparam logic [2:0] MT_HEARTBEAT = 3'd3;
  localparam logic [2:0] MT_LOGON     = 3'd4;
  localparam logic [2:0] MT_LOGOUT    = 3'd5;
  localparam logic [2:0] MT_ABSENT    = 3'd6;
  localparam logic [2:0] MT_UNKNOWN   = MT_HEARTBEAT;

  // Parser phase codes
  localparam logic PHASE_TAG   = 1'b0;
  localparam logic PHASE_VALUE = 1'b1;

  // Special characters and limits
  localparam logic [7:0]  CH_EQUAL   = 8'h3D;
  localparam logic [7:0]  CH_ZERO    = 8'h30;
  localparam logic [7:0]  CH_NINE    = 8'h39;
  localparam logic [15:0] TAG_MSGTYPE = 16'd35;
  localparam logic [15:0] TAG_CHKSUM  = 16'd10;
  localparam logic [15:0] TAG_MAX     = 16'hFFFF;
  localparam logic [2:0]  VLEN_BAD    = 3'd7;
  localparam logic [2:0]  VLEN_CKMAX  = 3'd3;
  localparam logic [3:0]  BCNT_MIN    = 4'd10;
  localparam logic [7:0]  SEP_RESET   = 8'h01;

  // Register indexes
  localparam logic REG_SEPARATOR = 1'b0;

  // Map the single message-type byte to its code
  function automatic logic [2:0] type_of(input logic [7:0] b);
    logic [2:0] t;
    case (b)
      8'h44:   t = MT_NEW_ORDER; // 'D'
      8'h46:   t = MT_CANCEL;    // 'F'
      8'h38:   t = MT_EXEC_RPT;  // '8'
      8'h30:   t = MT_HEARTBEAT; // '0'
      8'h41:   t = MT_LOGON;     // 'A'
      8'h35:   t = MT_LOGOUT;    // '5'
      default: t = MT_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== design/ftvp_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftvp_cfg
// APB-style register file holding the field separator byte.
// ----------------------------------------------------------------------------
module ftvp_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [7:0]       sep_o
);
  import ftvp_pkg::*;

  logic [7:0] sep_q;
  logic [7:0] sep_d;
  logic       wr_sep;

  assign pready = 1'b1;

  // Write the separator in the access phase
  assign wr_sep = psel && penable && pwrite && (paddr[2] == REG_SEPARATOR);
  assign sep_d  = wr_sep ? pwdata[7:0] : sep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else begin
      sep_q <= sep_d;
    end
  end

  // Read back; unused addresses return zero
  assign prdata = (paddr[2] == REG_SEPARATOR) ? {24'd0, sep_q} : 32'd0;
  assign sep_o  = sep_q;

endmodule
`default_nettype wire

// ===== design/ftvp_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftvp_core
// Per-byte parser state and the single-pass step logic that builds one result.
// ----------------------------------------------------------------------------
module ftvp_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire ftvp_pkg::in_item_t item_i,
  input  wire logic [7:0]         sep_i,
  output ftvp_pkg::out_item_t     res_o
);
  import ftvp_pkg::*;

  logic        phase_q,  phase_d;
  logic [15:0] tag_q,    tag_d;
  logic [7:0]  sum_q,    sum_d;
  logic [7:0]  fstart_q, fstart_d;
  logic [9:0]  ck_q,     ck_d;
  logic [2:0]  vlen_q,   vlen_d;
  logic [2:0]  type_q,   type_d;
  logic [3:0]  bcnt_q,   bcnt_d;

  logic [7:0]  b;
  logic        digit;
  logic [3:0]  dval;
  logic [19:0] tag_mul;
  logic        has_value;
  logic        ok;
  out_item_t   res;

  assign b       = item_i.data_byte;
  assign digit   = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval    = 4'(b - CH_ZERO);
  assign tag_mul = ({4'd0, tag_q} << 3) + ({4'd0, tag_q} << 1) + {16'd0, dval};

  always_comb begin
    phase_d   = phase_q;
    tag_d     = tag_q;
    fstart_d  = fstart_q;
    ck_d      = ck_q;
    vlen_d    = vlen_q;
    type_d    = type_q;
    has_value = 1'b0;
    res       = '0;
    sum_d     = sum_q + b;
    bcnt_d    = (bcnt_q < BCNT_MIN) ? bcnt_q + 4'd1 : bcnt_q;

    if (b == sep_i) begin
      // Separator ends the field in either phase
      if (phase_q == PHASE_VALUE) begin
        has_value = 1'b1;
        if (tag_q == TAG_MSGTYPE && vlen_q == 3'd0) begin
          type_d = MT_UNKNOWN;
        end
      end
      res.kind      = KIND_FEND;
      res.field_tag = tag_q;
      phase_d       = PHASE_TAG;
      tag_d         = '0;
      fstart_d      = sum_d;
    end else if (phase_q == PHASE_TAG) begin
      // Collect tag digits up to '='
      if (b == CH_EQUAL) begin
        phase_d = PHASE_VALUE;
        vlen_d  = '0;
        ck_d    = '0;
      end else if (digit) begin
        tag_d = (tag_mul > {4'd0, TAG_MAX}) ? TAG_MAX : tag_mul[15:0];
      end
      res.field_tag = tag_d;
    end else begin
      // Stream the value byte and track checksum digits
      if (tag_q == TAG_MSGTYPE) begin
        type_d = (vlen_q == 3'd0) ? type_of(b) : MT_UNKNOWN;
      end
      if (digit) begin
        if (vlen_q < VLEN_CKMAX) begin
          ck_d = (ck_q << 3) + (ck_q << 1) + {6'd0, dval};
        end
        if (vlen_q < VLEN_BAD) begin
          vlen_d = vlen_q + 3'd1;
        end
      end else begin
        vlen_d = VLEN_BAD;
      end
      has_value      = 1'b1;
      res.kind       = KIND_VALUE;
      res.field_tag  = tag_q;
      res.value_byte = b;
    end

    ok = (bcnt_d >= BCNT_MIN) && has_value && (tag_q == TAG_CHKSUM) &&
         (vlen_d >= 3'd1) && (vlen_d <= VLEN_CKMAX) && (ck_d[7:0] == fstart_q);

    // Verdict replaces the byte's own result and clears the state
    if (item_i.last_byte) begin
      res.kind         = ok ? KIND_ACCEPT : KIND_REJECT;
      res.field_tag    = tag_q;
      res.value_byte   = '0;
      res.message_type = type_d;
      phase_d  = PHASE_TAG;
      tag_d    = '0;
      sum_d    = '0;
      fstart_d = '0;
      ck_d     = '0;
      vlen_d   = '0;
      type_d   = MT_ABSENT;
      bcnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PHASE_TAG;
      tag_q    <= '0;
      sum_q    <= '0;
      fstart_q <= '0;
      ck_q     <= '0;
      vlen_q   <= '0;
      type_q   <= MT_ABSENT;
      bcnt_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      tag_q    <= tag_d;
      sum_q    <= sum_d;
      fstart_q <= fstart_d;
      ck_q     <= ck_d;
      vlen_q   <= vlen_d;
      type_q   <= type_d;
      bcnt_q   <= bcnt_d;
    end
  end

  assign res_o = res;

endmodule
`default_nettype wire

// ===== design/fix_tag_value_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fix_tag_value_parser
// FIX tag=value byte parser: labels value bytes with their tag, flags field
// ends and gives a checksum verdict with the message type on the last byte.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i/in_ready_o   in_item_i  (data_byte, last_byte)
// out       output     out_valid_o/out_ready_i out_item_o (kind, field_tag,
//                                              value_byte, message_type)
// cfg       input      psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// One byte per cycle sustained while results are taken; each byte gives one
// result after its transfer through the input register, then the result register.
// The parser state feeds back through its own registers, which sets the byte rate.
// Reset clears the parser state and sets the separator to 0x01.
// A stalled result holds in the output register; the input register still
// takes a byte if it is empty, and in_ready_o stays low while it is full.
// ----------------------------------------------------------------------------
module fix_tag_value_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ftvp_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ftvp_pkg::out_item_t      out_item_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import ftvp_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      advance;
  logic      in_fire;
  logic [7:0] sep;
  out_item_t res;

  ftvp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sep_o   (sep)
  );

  // Move the held byte into the result register when it has room
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  ftvp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .sep_i  (sep),
    .res_o  (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An empty result register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // Value byte is only carried by value results
  a_vbyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind != KIND_VALUE) |-> (out_item_o.value_byte == 8'd0))
    else $error("value byte set on non-value result");

  // Message type is only carried by verdicts
  a_mtype_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.kind != KIND_ACCEPT) && (out_item_o.kind != KIND_REJECT)
      |-> (out_item_o.message_type == 3'd0))
    else $error("message type set outside a verdict");

endmodule
`default_nettype wire

// ===== tb/sv/ftvp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ftvp_checker
// Watches the byte and result channels and the register port of the FIX
// tag=value parser. It predicts one result for every byte transfer and
// compares each result transfer, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module ftvp_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ftvp_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ftvp_pkg::out_item_t out_item_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [2:0]          paddr_i,
  input  logic [31:0]         pwdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import ftvp_pkg::*;

  localparam logic [7:0] CHR_D     = "D";
  localparam logic [7:0] CHR_F     = "F";
  localparam logic [7:0] CHR_8     = "8";
  localparam logic [7:0] CHR_0     = "0";
  localparam logic [7:0] CHR_A     = "A";
  localparam logic [7:0] CHR_5     = "5";
  localparam logic [7:0] CHR_9     = "9";
  localparam logic [7:0] CHR_EQ    = "=";
  localparam logic [3:0] MIN_BYTES = 4'd10;
  localparam logic [2:0] LEN_BAD   = 3'd7;

  // Parser state as the predictor sees it
  logic        in_value;
  logic [15:0] tag_acc;
  logic [7:0]  byte_sum;
  logic [7:0]  field_start_sum;
  logic [9:0]  ck_value;
  logic [2:0]  value_len;
  logic [2:0]  msg_type;
  logic [3:0]  byte_total;
  logic [7:0]  sep_char;

  out_item_t   parsed_results_q[$];

  // Map a single message-type byte to its code
  function automatic logic [2:0] msg_type_of(input logic [7:0] b);
    case (b)
      CHR_D:   return MT_NEW_ORDER;
      CHR_F:   return MT_CANCEL;
      CHR_8:   return MT_EXEC_RPT;
      CHR_0:   return MT_HEARTBEAT;
      CHR_A:   return MT_LOGON;
      CHR_5:   return MT_LOGOUT;
      default: return MT_UNKNOWN;
    endcase
  endfunction

  task automatic clear_message();
    in_value        = 1'b0;
    tag_acc         = '0;
    byte_sum        = '0;
    field_start_sum = '0;
    ck_value        = '0;
    value_len       = '0;
    msg_type        = MT_ABSENT;
    byte_total      = '0;
  endtask

  // Advance the parser by one byte and return the result it gives
  task automatic parse_byte(input in_item_t item, output out_item_t res);
    logic [7:0]  b;
    logic [15:0] ftag;
    logic [7:0]  fstart;
    logic        had_value;
    logic        is_digit;
    int unsigned t;
    b         = item.data_byte;
    ftag      = tag_acc;
    fstart    = field_start_sum;
    had_value = 1'b0;
    is_digit  = (b >= CHR_0) && (b <= CHR_9);
    res       = '0;
    byte_sum  = byte_sum + b;
    if (byte_total < MIN_BYTES) byte_total++;

    if (b == sep_char) begin
      // Separator wins over every other meaning of the byte
      if (in_value) begin
        had_value = 1'b1;
        if (ftag == TAG_MSGTYPE && value_len == 0) msg_type = MT_UNKNOWN;
      end
      res.kind        = KIND_FEND;
      res.field_tag   = ftag;
      in_value        = 1'b0;
      tag_acc         = '0;
      field_start_sum = byte_sum;
    end else if (!in_value) begin
      if (b == CHR_EQ) begin
        in_value  = 1'b1;
        value_len = '0;
        ck_value  = '0;
      end else if (is_digit) begin
        t       = 32'(tag_acc) * 10 + 32'(b - CHR_0);
        tag_acc = (t > 32'hFFFF) ? 16'hFFFF : t[15:0];
      end
      res.kind      = KIND_NONE;
      res.field_tag = tag_acc;
    end else begin
      if (ftag == TAG_MSGTYPE) msg_type = (value_len == 0) ? msg_type_of(b) : MT_UNKNOWN;
      if (is_digit) begin
        if (value_len < 3) ck_value = ck_value * 10 + 10'(b - CHR_0);
        if (value_len < LEN_BAD) value_len++;
      end else begin
        value_len = LEN_BAD;
      end
      had_value       = 1'b1;
      res.kind        = KIND_VALUE;
      res.field_tag   = ftag;
      res.value_byte  = b;
    end

    // Replace the result with the verdict on the final byte
    if (item.last_byte) begin
      res.kind = (byte_total >= MIN_BYTES && had_value && ftag == TAG_CHKSUM &&
                  value_len >= 1 && value_len <= 3 && ck_value[7:0] == fstart)
                 ? KIND_ACCEPT : KIND_REJECT;
      res.field_tag    = ftag;
      res.value_byte   = '0;
      res.message_type = msg_type;
      clear_message();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    out_item_t pred;
    if (!rst_ni) begin
      clear_message();
      sep_char = SEP_RESET;
      parsed_results_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == {REG_SEPARATOR, 2'b00})
        sep_char = pwdata_i[7:0];

      // Compare a result transfer with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (parsed_results_q.size() == 0) begin
          $error("unexpected result: kind %0d tag %0d", out_item_i.kind, out_item_i.field_tag);
          fail_count_o++;
        end else begin
          want = parsed_results_q.pop_front();
          if (out_item_i.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_item_i.kind);
            fail_count_o++;
          end
          if (out_item_i.field_tag !== want.field_tag) begin
            $error("field_tag: expected %0d, got %0d", want.field_tag, out_item_i.field_tag);
            fail_count_o++;
          end
          if (out_item_i.value_byte !== want.value_byte) begin
            $error("value_byte: expected %0h, got %0h", want.value_byte, out_item_i.value_byte);
            fail_count_o++;
          end
          if (out_item_i.message_type !== want.message_type) begin
            $error("message_type: expected %0d, got %0d",
                   want.message_type, out_item_i.message_type);
            fail_count_o++;
          end
        end
      end

      // Predict the result of a byte transfer
      if (in_valid_i && in_ready_i) begin
        parse_byte(in_item_i, pred);
        parsed_results_q.push_back(pred);
      end
      pending_o = parsed_results_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds FIX messages byte by byte into the tag=value parser: a directed set
// of corner-case messages, then random well-formed, broken and noise traffic
// under several separator settings, with random gaps on both channels and
// one long output stall. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import ftvp_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_LIMIT = 5000;

  typedef enum {CK_GOOD, CK_PADDED, CK_BAD, CK_LONG, CK_EMPTY, CK_ALPHA} ck_mode_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  bit          idle_enable;
  bit          hold_request;
  logic [7:0]  sep_char;
  int          sent_count;
  logic [7:0]  frame_q[$];
  string       type_choices [9] = '{"D", "F", "8", "0", "A", "5", "Q", "AB", ""};

  fix_tag_value_parser uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  ftvp_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    int n;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_request = 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 8);
        repeat (n - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if (idle_enable) begin
          n = $urandom_range(1, 8);
          repeat (n - 1) @(posedge clk);
        end
      end
    end
  end

  // Offer one byte, with an optional gap first, and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endtask

  task automatic put_sep();
    frame_q.push_back(sep_char);
  endtask

  // Random value bytes, mostly printable, never the separator
  task automatic put_random_value(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      do begin
        b = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(33, 126));
      end while (b == sep_char);
      frame_q.push_back(b);
    end
  endtask

  // Append the checksum field over everything queued so far
  task automatic put_checksum(input ck_mode_e mode, input bit terminated);
    logic [7:0] sum;
    int         v;
    string      digits;
    sum = '0;
    foreach (frame_q[i]) sum += frame_q[i];
    v = sum;
    case (mode)
      CK_GOOD: begin
        if ($urandom_range(0, 3) == 0) v += 256 * $urandom_range(1, (999 - v) / 256);
        digits = $sformatf("%0d", v);
      end
      CK_PADDED: digits = $sformatf("%03d", v);
      CK_BAD:    digits = $sformatf("%0d", (v + $urandom_range(1, 255)) % 256);
      CK_LONG:   digits = $sformatf("%04d", v);
      CK_EMPTY:  digits = "";
      default:   digits = $sformatf("%0dx", v);
    endcase
    put_text({"10=", digits});
    if (terminated) put_sep();
  endtask

  function automatic int unsigned pick_tag();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1000, 999999);
      1:       return TAG_CHKSUM;
      2:       return TAG_MSGTYPE;
      default: return $urandom_range(1, 999);
    endcase
  endfunction

  // Queue a message: optional header and type, zero or more body fields, checksum
  task automatic build_message(input ck_mode_e mode, input bit terminated);
    int n;
    if ($urandom_range(0, 3) != 0) begin
      put_text("8=FIX.4.4");
      put_sep();
      put_text($sformatf("9=%0d", $urandom_range(0, 300)));
      put_sep();
    end
    if ($urandom_range(0, 5) != 0) begin
      put_text({"35=", type_choices[$urandom_range(0, 8)]});
      put_sep();
    end
    n = $urandom_range(0, 4);
    repeat (n) begin
      put_text($sformatf("%0d=", pick_tag()));
      put_random_value($urandom_range(1, 8));
      put_sep();
    end
    put_checksum(mode, terminated);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++)
      send_byte(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 9) == 0);
  endtask

  // Mostly well-formed messages, the rest broken or noise
  task automatic run_random(input int count, input bit with_idle);
    int       stop_at;
    int       pick;
    ck_mode_e mode;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      idle_enable = with_idle && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_noise();
      end else begin
        if (pick == 2) mode = ck_mode_e'($urandom_range(CK_BAD, CK_ALPHA));
        else mode = ($urandom_range(0, 2) == 0) ? CK_PADDED : CK_GOOD;
        build_message(mode, $urandom_range(0, 3) != 0);
        if (pick == 1) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 1)];
        send_frame();
      end
    end
  endtask

  // Drop valid and wait until every result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_separator(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SEPARATOR, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    sep_char = value;
  endtask

  initial begin : stimulus
    logic [7:0] sep_list [6];
    int         waited;
    in_valid     = 1'b0;
    in_item      = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    idle_enable  = 1'b1;
    hold_request = 1'b0;
    sep_char     = SEP_RESET;
    sent_count   = 0;
    sep_list     = '{8'h00, 8'hFF, 8'h7C, CH_EQUAL, 8'($urandom_range(0, 255)), SEP_RESET};

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty tag, tag overflow, non-digit in tag, '=' in value, field without value
    put_text("=x");         put_sep();
    put_text("123456789=v"); put_sep();
    put_text("9a9=q=r");    put_sep();
    put_text("5");          put_sep();
    put_text("35=D");       put_sep();
    put_checksum(CK_GOOD, 1'b1);
    send_frame();
    // Long type value, unterminated checksum field
    put_text("35=AB"); put_sep();
    put_checksum(CK_PADDED, 1'b0);
    send_frame();
    // Too short, empty type value, empty checksum
    put_text("35="); put_sep();
    put_checksum(CK_EMPTY, 1'b1);
    send_frame();
    // Byte extremes in a value, non-digit in checksum
    put_text("58=");
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    put_sep();
    put_checksum(CK_ALPHA, 1'b1);
    send_frame();
    // Four checksum digits
    put_text("1=2"); put_sep();
    put_checksum(CK_LONG, 1'b1);
    send_frame();
    // Message ending inside a tag
    put_text("1=2"); put_sep();
    put_text("10");
    send_frame();
    settle();

    // Random traffic per separator setting; stall the results once, no gaps at the end
    foreach (sep_list[i]) begin
      write_separator(sep_list[i]);
      if (i == 1) hold_request = 1'b1;
      run_random(sep_list[i] == CH_EQUAL ? 40 : 140, i != 5);
      settle();
    end

    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ftvp_pkg.sv
design/ftvp_cfg.sv
design/ftvp_core.sv
design/fix_tag_value_parser.sv
tb/sv/ftvp_checker.sv
tb/sv/testbench.sv
